@@ sv/qlye_pkg.sv @@
// Package for the quaternion level-yaw extraction unit.
// Holds widths, CORDIC constants and the arctangent table; depends on nothing.
package qlye_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int NSTEPS = (CORDIC_STEPS > ANG_TABLE_LEN) ? ANG_TABLE_LEN : CORDIC_STEPS;
    // Vectoring datapath: magnitude is normalized to [2^38, 2^39), growth stays below 2^41.
    localparam int VW = 42;
    localparam int AW = 23;
    localparam int SCALE_BIT = 38;
    localparam logic signed [AW-1:0] HALF_PI_ANG = 23'sd1647099;
    localparam logic signed [15:0] YAW_LIMIT = 16'sd25736;
    localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;
    localparam int RW = 33;

    function automatic logic signed [AW-1:0] atan_ang(input int i);
        logic signed [AW-1:0] v;
        unique case (i)
            0: v = 23'sd823550;  1: v = 23'sd486170;  2: v = 23'sd256879;
            3: v = 23'sd130396;  4: v = 23'sd65451;   5: v = 23'sd32757;
            6: v = 23'sd16383;   7: v = 23'sd8192;    8: v = 23'sd4096;
            9: v = 23'sd2048;    10: v = 23'sd1024;   11: v = 23'sd512;
            12: v = 23'sd256;    13: v = 23'sd128;    14: v = 23'sd64;
            15: v = 23'sd32;     16: v = 23'sd16;     17: v = 23'sd8;
            18: v = 23'sd4;      19: v = 23'sd2;      20: v = 23'sd1;
            default: v = 23'sd0;
        endcase
        return v;
    endfunction
endpackage

@@ sv/quaternion_level_yaw_extract_unit.sv @@
// Top level of the quaternion level-yaw extraction unit.
// Pipelined products, normalization, vectoring and rotation CORDICs; uses qlye_pkg.
//
// channel | direction | handshake        | payload
// command | in        | i_start, o_busy  | i_goal_w, i_goal_x, i_goal_y, i_goal_z
// result  | out       | o_valid strobe   | o_level_w, o_level_z, o_yaw_angle, o_valid_res
//
// One beat enters per cycle; o_busy is always low. A result leaves after the
// product, normalization and yaw stages, the two chained CORDIC pipelines and the output register.
// Reset clears only the valid bits of the stages. The receiver cannot stall, so
// the pipeline never holds.
module quaternion_level_yaw_extract_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic signed [15:0] i_goal_w,
    input  logic signed [15:0] i_goal_x,
    input  logic signed [15:0] i_goal_y,
    input  logic signed [15:0] i_goal_z,
    output logic        o_valid,
    output logic [14:0] o_level_w,
    output logic signed [15:0] o_level_z,
    output logic signed [15:0] o_yaw_angle,
    output logic        o_valid_res
);
    import qlye_pkg::*;

    localparam int NV = NSTEPS + 1;
    localparam int LAT = 2 * NSTEPS + 6;

    // Valid and nonzero flags ride along in shift lines.
    logic [LAT-1:0] r_vld, r_nz;

    // Stage 1: products.
    logic signed [31:0] r_p_xy, r_p_wz, r_p_ww, r_p_xx, r_p_yy, r_p_zz;
    // Stage 2: rotation terms.
    logic signed [VW-1:0] r_r00, r_r10;
    // Stage 3: normalization and pre-rotation.
    logic signed [VW-1:0] r_vx [NV];
    logic signed [VW-1:0] r_vy [NV];
    logic signed [AW-1:0] r_vz [NV];
    logic                 r_vzero [NV];
    // Yaw stage.
    logic signed [15:0] r_yaw;
    logic signed [15:0] r_yaw_d [NV];
    logic signed [RW-1:0] r_rx [NV];
    logic signed [RW-1:0] r_ry [NV];
    logic signed [AW-1:0] r_rz [NV];
    logic [14:0] r_lw;
    logic signed [15:0] r_lz, r_ya;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_nz   <= {r_nz[LAT-2:0], (i_goal_w != 0) || (i_goal_x != 0) ||
                   (i_goal_y != 0) || (i_goal_z != 0)};
        r_p_xy <= i_goal_x * i_goal_y;
        r_p_wz <= i_goal_w * i_goal_z;
        r_p_ww <= i_goal_w * i_goal_w;
        r_p_xx <= i_goal_x * i_goal_x;
        r_p_yy <= i_goal_y * i_goal_y;
        r_p_zz <= i_goal_z * i_goal_z;
        r_r10  <= VW'(({{(VW-32){r_p_xy[31]}}, r_p_xy} + {{(VW-32){r_p_wz[31]}}, r_p_wz}) <<< 1);
        r_r00  <= VW'(r_p_ww) + VW'(r_p_xx) - VW'(r_p_yy) - VW'(r_p_zz);
    end

    // Normalize so max(|x|,|y|) lands in [2^38, 2^39), then pre-rotate the left half-plane.
    logic [VW-1:0] n_ax, n_ay, n_m;
    logic [5:0]    n_k;
    logic signed [VW-1:0] n_sx, n_sy, n_px, n_py;
    logic signed [AW-1:0] n_pz;
    always_comb begin
        n_ax = r_r00[VW-1] ? VW'(-r_r00) : VW'(r_r00);
        n_ay = r_r10[VW-1] ? VW'(-r_r10) : VW'(r_r10);
        n_m  = (n_ax > n_ay) ? n_ax : n_ay;
        n_k  = '0;
        for (int b = 0; b <= SCALE_BIT; b++) begin
            if (n_m[b]) n_k = 6'(SCALE_BIT - b);
        end
        n_sx = r_r00 <<< n_k;
        n_sy = r_r10 <<< n_k;
        n_px = n_sx;
        n_py = n_sy;
        n_pz = '0;
        if (n_sx[VW-1]) begin
            if (!n_sy[VW-1]) begin
                n_px = n_sy; n_py = -n_sx; n_pz = HALF_PI_ANG;
            end else begin
                n_px = -n_sy; n_py = n_sx; n_pz = -HALF_PI_ANG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vx[0]    <= n_px;
        r_vy[0]    <= n_py;
        r_vz[0]    <= n_pz;
        r_vzero[0] <= (n_m == 0);
    end

    genvar g;
    generate
        for (g = 0; g < NSTEPS; g++) begin : g_vec
            always_ff @(posedge i_clk) begin
                r_vzero[g+1] <= r_vzero[g];
                if (!r_vy[g][VW-1]) begin
                    r_vx[g+1] <= r_vx[g] + (r_vy[g] >>> g);
                    r_vy[g+1] <= r_vy[g] - (r_vx[g] >>> g);
                    r_vz[g+1] <= r_vz[g] + atan_ang(g);
                end else begin
                    r_vx[g+1] <= r_vx[g] - (r_vy[g] >>> g);
                    r_vy[g+1] <= r_vy[g] + (r_vx[g] >>> g);
                    r_vz[g+1] <= r_vz[g] - atan_ang(g);
                end
            end
        end
    endgenerate

    // Round the angle to Q3.13, half away from zero, and clamp.
    logic signed [AW-1:0] n_ang;
    logic signed [AW-1:0] n_mag;
    logic signed [AW-1:0] n_y;
    always_comb begin
        n_ang = r_vzero[NSTEPS] ? '0 : r_vz[NSTEPS];
        n_mag = n_ang[AW-1] ? -n_ang : n_ang;
        n_mag = (n_mag + AW'(64)) >>> 7;
        n_y   = n_ang[AW-1] ? -n_mag : n_mag;
        if (n_y > AW'(YAW_LIMIT)) n_y = AW'(YAW_LIMIT);
        if (n_y < -AW'(YAW_LIMIT)) n_y = -AW'(YAW_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        r_yaw      <= 16'(n_y);
        r_yaw_d[0] <= r_yaw;
        r_rx[0]    <= RW'(CORDIC_GAIN_INV);
        r_ry[0]    <= '0;
        r_rz[0]    <= AW'(r_yaw) <<< 6;
    end

    generate
        for (g = 0; g < NSTEPS; g++) begin : g_rot
            always_ff @(posedge i_clk) begin
                r_yaw_d[g+1] <= r_yaw_d[g];
                if (!r_rz[g][AW-1]) begin
                    r_rx[g+1] <= r_rx[g] - (r_ry[g] >>> g);
                    r_ry[g+1] <= r_ry[g] + (r_rx[g] >>> g);
                    r_rz[g+1] <= r_rz[g] - atan_ang(g);
                end else begin
                    r_rx[g+1] <= r_rx[g] + (r_ry[g] >>> g);
                    r_ry[g+1] <= r_ry[g] - (r_rx[g] >>> g);
                    r_rz[g+1] <= r_rz[g] + atan_ang(g);
                end
            end
        end
    endgenerate

    logic signed [RW-1:0] n_c, n_s;
    logic nz_out;
    assign nz_out = r_nz[LAT-2];
    always_comb begin
        n_c = (r_rx[NSTEPS] + RW'(16384)) >>> 15;
        n_s = (r_ry[NSTEPS] + RW'(16384)) >>> 15;
        if (n_c < 0) n_c = '0;
        if (n_c > RW'(32767)) n_c = RW'(32767);
        if (n_s > RW'(32767)) n_s = RW'(32767);
        if (n_s < -RW'(32767)) n_s = -RW'(32767);
    end

    always_ff @(posedge i_clk) begin
        r_lw <= nz_out ? n_c[14:0] : '0;
        r_lz <= nz_out ? n_s[15:0] : '0;
        r_ya <= nz_out ? r_yaw_d[NSTEPS] : '0;
    end

    assign o_valid     = r_vld[LAT-1];
    assign o_level_w   = r_lw;
    assign o_level_z   = r_lz;
    assign o_yaw_angle = r_ya;
    assign o_valid_res = r_nz[LAT-1];
endmodule

@@ sv/qlye_checker.sv @@
// Port-level checker for the quaternion level-yaw extraction unit.
// Sees only the top-level ports; bound to the top level below.
module qlye_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_busy,
    input logic        o_valid,
    input logic [14:0] o_level_w,
    input logic signed [15:0] o_level_z,
    input logic signed [15:0] o_yaw_angle,
    input logic        o_valid_res
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_level_w == 0 && o_level_z == 0 && o_yaw_angle == 0))
        else $error("degenerate beat carries nonzero data");
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_yaw_angle <= 16'sd25736 && o_yaw_angle >= -16'sd25736))
        else $error("yaw out of range");
    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level_z >= -16'sd32767))
        else $error("sine below its clamp");
endmodule

bind quaternion_level_yaw_extract_unit qlye_checker u_qlye_checker (.*);
